### src/tmds_pkg.sv
// Shared types and constants for the two disjoint max subarray block.
`timescale 1ns / 1ps

package tmds_pkg;

    localparam int MAX_LEN_DEF      = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int SUM_BITS         = 26;
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // control part of one queue entry
    typedef struct packed {
        logic    do_store;  // entry carries a sample to write
        logic    is_end;    // entry closes the sequence
        t_status status;    // sequence status, meaningful with is_end
    } t_qctl;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_WALK,
        BS_OUT
    } t_bstate;

endpackage

### src/tmds_front.sv
// Front end: accepts samples, runs forward Kadane, classifies each transaction.
`timescale 1ns / 1ps

module tmds_front #(
    parameter int MAX_LEN      = tmds_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_WIDTH = tmds_pkg::SAMPLE_WIDTH_DEF,
    localparam int LW          = SAMPLE_WIDTH + $clog2(MAX_LEN) + 1,
    localparam int CW          = $clog2(MAX_LEN + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last,
    input  logic                           i_full,
    output logic                           o_push,
    output tmds_pkg::t_qctl                o_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample,
    output logic signed [LW-1:0]           o_left_best,
    output logic [CW-1:0]                  o_count
);
    import tmds_pkg::*;

    logic [CW-1:0]        r_count;
    logic signed [LW-1:0] r_end_sum;
    logic signed [LW-1:0] r_run_best;
    logic                 r_ovf;

    logic                 accept;
    logic                 has_room;
    logic                 first;
    logic signed [LW-1:0] s_ext;
    logic signed [LW-1:0] end_sum;
    logic signed [LW-1:0] end_new;
    logic signed [LW-1:0] best_new;
    logic [CW-1:0]        count_new;
    logic                 ovf_new;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign has_room = r_count < CW'(MAX_LEN);
    assign first    = r_count == '0;
    assign s_ext    = LW'(i_sample);

    always_comb begin
        end_sum   = r_end_sum + s_ext;
        end_new   = first ? s_ext : ((end_sum > s_ext) ? end_sum : s_ext);
        best_new  = first ? s_ext : ((r_run_best > end_new) ? r_run_best : end_new);
        count_new = has_room ? r_count + CW'(1) : r_count;
        ovf_new   = r_ovf || !has_room;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_end_sum  <= '0;
            r_run_best <= '0;
            r_ovf      <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_count    <= '0;
                r_end_sum  <= '0;
                r_run_best <= '0;
                r_ovf      <= 1'b0;
            end else begin
                if (has_room) begin
                    r_count    <= count_new;
                    r_end_sum  <= end_new;
                    r_run_best <= best_new;
                end
                r_ovf <= ovf_new;
            end
        end
    end

    always_comb begin
        o_push         = accept;
        o_ctl.do_store = has_room;
        o_ctl.is_end   = i_last;
        if (ovf_new) begin
            o_ctl.status = ST_OVERFLOW;
        end else if (count_new < CW'(2)) begin
            o_ctl.status = ST_SHORT;
        end else begin
            o_ctl.status = ST_OK;
        end
        o_sample    = i_sample;
        o_left_best = best_new;
        o_count     = count_new;
    end

endmodule

### src/tmds_queue.sv
// Short FIFO between the front end and the back end.
`timescale 1ns / 1ps

module tmds_queue #(
    parameter int DW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tmds_pkg::t_qctl i_push_ctl,
    input  logic [DW-1:0]   i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tmds_pkg::t_qctl o_ctl,
    output logic [DW-1:0]   o_data
);
    import tmds_pkg::*;

    localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    t_qctl         r_ctl  [QUEUE_DEPTH];
    logic [DW-1:0] r_data [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CNW-1:0] r_cnt;

    assign o_full  = r_cnt == CNW'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_ctl   = r_ctl[r_rd];
    assign o_data  = r_data[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr]  <= i_push_ctl;
            r_data[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNW'(1);
                2'b01:   r_cnt <= r_cnt - CNW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNW'(QUEUE_DEPTH))
        else $error("queue fill count past depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> !o_full)
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

### src/tmds_back.sv
// Back end: sample/left-best memory, backward Kadane walk, result register.
`timescale 1ns / 1ps

module tmds_back #(
    parameter int MAX_LEN      = tmds_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_WIDTH = tmds_pkg::SAMPLE_WIDTH_DEF,
    localparam int LW          = SAMPLE_WIDTH + $clog2(MAX_LEN) + 1,
    localparam int CW          = $clog2(MAX_LEN + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_avail,
    output logic                                 o_pop,
    input  tmds_pkg::t_qctl                      i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    input  logic signed [LW-1:0]                 i_left_best,
    input  logic [CW-1:0]                        i_count,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [tmds_pkg::SUM_BITS-1:0] o_best_sum,
    output tmds_pkg::t_status                    o_status
);
    import tmds_pkg::*;

    localparam int AW  = $clog2(MAX_LEN);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int RW  = SW + LW;
    localparam int XW  = (LW + 1 > SUM_BITS) ? LW + 1 : SUM_BITS;

    logic [RW-1:0] r_mem [MAX_LEN];

    t_bstate               r_state;
    t_bstate               n_state;
    logic [RW-1:0]         r_rd_data;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_idx;
    logic [CW-1:0]         r_left;
    logic                  r_head;
    logic                  r_ans_first;
    logic signed [LW-1:0]  r_re;
    logic signed [LW-1:0]  r_rb;
    logic signed [LW:0]    r_ans;
    logic signed [SUM_BITS-1:0] r_best;
    t_status               r_status;

    logic                  pop;
    logic                  wr_en;
    logic                  rd_en;
    logic                  walk_done;
    logic                  seq_end;
    logic [CW-1:0]         nm1;
    logic signed [SW-1:0]  rd_s;
    logic signed [LW-1:0]  rd_l;
    logic signed [LW-1:0]  s_ext;
    logic signed [LW-1:0]  re_sum;
    logic signed [LW-1:0]  re_new;
    logic signed [LW-1:0]  rb_new;
    logic signed [LW:0]    cand;
    logic signed [LW:0]    ans_new;
    logic signed [XW-1:0]  ans_ext;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_avail && i_ctl.is_end) begin
                    n_state = (i_ctl.status == ST_OK) ? BS_WALK : BS_OUT;
                end
            end
            BS_WALK: begin
                if (walk_done) begin
                    n_state = BS_OUT;
                end
            end
            BS_OUT: begin
                if (i_ready) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop       = (r_state == BS_IDLE) && i_avail;
        wr_en     = pop && i_ctl.do_store;
        seq_end   = pop && i_ctl.is_end;
        rd_en     = (r_state == BS_WALK) && (r_left != '0);
        walk_done = (r_state == BS_WALK) && (r_left == '0) && !r_rd_vld;
        o_valid   = r_state == BS_OUT;
    end

    assign o_pop = pop;
    assign nm1   = i_count - CW'(1);

    // memory: one write in idle, one read per walk cycle while entries remain
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[nm1[AW-1:0]] <= {i_sample, i_left_best};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // mirrored Kadane step on the entry just read
    always_comb begin
        rd_s    = r_rd_data[RW-1:LW];
        rd_l    = r_rd_data[LW-1:0];
        s_ext   = LW'(rd_s);
        re_sum  = r_re + s_ext;
        re_new  = (re_sum > s_ext) ? re_sum : s_ext;
        rb_new  = (r_rb > re_new) ? r_rb : re_new;
        cand    = (LW + 1)'(rd_l) + (LW + 1)'(r_rb);
        ans_new = (r_ans_first || (cand > r_ans)) ? cand : r_ans;
        ans_ext = XW'(r_ans);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_rd_vld <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (seq_end) begin
                r_left <= (i_ctl.status == ST_OK) ? i_count : '0;
            end else if (rd_en) begin
                r_left <= r_left - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_end) begin
            r_idx       <= nm1[AW-1:0];
            r_head      <= 1'b1;
            r_ans_first <= 1'b1;
            r_status    <= i_ctl.status;
            r_best      <= '0;
        end else begin
            if (rd_en) begin
                r_idx <= r_idx - AW'(1);
            end
            if (r_rd_vld) begin
                if (r_head) begin
                    r_re   <= s_ext;
                    r_rb   <= s_ext;
                    r_head <= 1'b0;
                end else begin
                    r_ans       <= ans_new;
                    r_ans_first <= 1'b0;
                    r_re        <= re_new;
                    r_rb        <= rb_new;
                end
            end
            if (walk_done) begin
                r_best <= ans_ext[SUM_BITS-1:0];
            end
        end
    end

    assign o_best_sum = r_best;
    assign o_status   = r_status;

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_status != ST_OK) |-> r_best == '0)
        else $error("nonzero sum with error status");

    a_read_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_state == BS_WALK)
        else $error("read data outside backward walk");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("result shown twice");

endmodule

### src/two_max_disjoint_subarray_sum.sv
// Top level: greatest sum of two disjoint subarrays of a sample sequence.
// Samples are taken one per cycle while the queue has room; forward Kadane keeps pace.
// Last sample: the back end walks the n stored samples backward, one read per cycle, then
// registers the result; short and overflow sequences skip the walk and go straight to the result.
// Sustained cost per sample is a load into memory plus a read in the backward walk.
// Reset (i_rst_n low, synchronous) clears counts, queue and walk state; memory is not cleared.
`timescale 1ns / 1ps

module two_max_disjoint_subarray_sum #(
    parameter int MAX_LEN      = tmds_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_WIDTH = tmds_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    input  logic                                 i_last,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [tmds_pkg::SUM_BITS-1:0] o_best_sum,
    output tmds_pkg::t_status                    o_status
);
    import tmds_pkg::*;

    // left sums hold up to MAX_LEN full-scale samples plus a sign bit
    localparam int LW = SAMPLE_WIDTH + $clog2(MAX_LEN) + 1;
    // sample count must reach MAX_LEN itself
    localparam int CW = $clog2(MAX_LEN + 1);
    // queue entry payload: sample, left best, count
    localparam int DW = SAMPLE_WIDTH + LW + CW;

    logic                           f_push;
    t_qctl                          f_ctl;
    logic signed [SAMPLE_WIDTH-1:0] f_sample;
    logic signed [LW-1:0]           f_left_best;
    logic [CW-1:0]                  f_count;

    logic                           q_full;
    logic                           q_empty;
    logic                           q_pop;
    t_qctl                          q_ctl;
    logic [DW-1:0]                  q_data;

    logic signed [SAMPLE_WIDTH-1:0] b_sample;
    logic signed [LW-1:0]           b_left_best;
    logic [CW-1:0]                  b_count;

    // front end: forward Kadane and classification of each transaction
    tmds_front #(
        .MAX_LEN      (MAX_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_full      (q_full),
        .o_push      (f_push),
        .o_ctl       (f_ctl),
        .o_sample    (f_sample),
        .o_left_best (f_left_best),
        .o_count     (f_count)
    );

    // decoupling queue; the front keeps loading while the back walks
    tmds_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .i_push_ctl  (f_ctl),
        .i_push_data ({f_sample, f_left_best, f_count}),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_ctl       (q_ctl),
        .o_data      (q_data)
    );

    assign b_sample    = q_data[DW-1 -: SAMPLE_WIDTH];
    assign b_left_best = q_data[CW +: LW];
    assign b_count     = q_data[CW-1:0];

    // back end: store, backward walk, result register
    tmds_back #(
        .MAX_LEN      (MAX_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (!q_empty),
        .o_pop       (q_pop),
        .i_ctl       (q_ctl),
        .i_sample    (b_sample),
        .i_left_best (b_left_best),
        .i_count     (b_count),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_best_sum  (o_best_sum),
        .o_status    (o_status)
    );

endmodule

### dv/two_max_disjoint_subarray_sum_test.sv
// Self-checking testbench for the two disjoint max subarray block.
`timescale 1ns / 1ps

module two_max_disjoint_subarray_sum_test;

    import tmds_pkg::*;

    // Geometry follows the block defaults
    localparam int FRAME_CAP      = MAX_LEN_DEF;
    localparam int SW             = SAMPLE_WIDTH_DEF;
    localparam int RANDOM_ITEMS   = 120;
    localparam int WATCHDOG_LIMIT = 6000;  // full backward walk plus long hold-off, with margin
    localparam int HOLD_OFF       = 400;   // long receiver stall used to fill the block
    localparam int SETTLE_CYCLES  = 64;    // quiet time after the last result
    localparam int REPORT_MAX     = 10;

    localparam logic signed [SW-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SW-1:0] SAMPLE_MAX = 16'sh7fff;

    // Sample content styles for random sequences
    typedef enum int {
        FILL_FULL,
        FILL_TINY,
        FILL_NEGATIVE,
        FILL_EXTREME
    } t_fill;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [SW-1:0]       i_sample;
    logic                       i_last;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [SUM_BITS-1:0] o_best_sum;
    t_status                    o_status;

    two_max_disjoint_subarray_sum u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_best_sum  (o_best_sum),
        .o_status    (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the sequence state, updated on every accepted sample
    // ------------------------------------------------------------------
    longint seq_samples   [FRAME_CAP];
    longint seq_left_best [FRAME_CAP];   // best subarray sum at or before each index
    int     seq_len       = 0;
    longint run_tail      = 0;           // best sum of a subarray ending at newest sample
    longint run_best      = 0;
    bit     seq_dropped   = 1'b0;        // a sample arrived with the store full

    // Expected results, oldest first
    logic [SUM_BITS-1:0] due_sums[$];
    logic [1:0]          due_status[$];

    int  samples_taken   = 0;
    int  sequences_taken = 0;
    int  answers_checked = 0;
    int  mismatch_count  = 0;
    int  quiet_cycles    = 0;

    // Knobs shared by the test tasks and the two channel drivers
    bit  src_no_idle  = 1'b0;
    bit  sink_no_idle = 1'b0;
    int  sink_hold    = 0;

    // Mirrored Kadane walk from the end: best right sum at or after i+1
    // combined with the stored best left sum at i, maximized over all splits.
    function automatic logic [SUM_BITS-1:0] best_pair_total(int n);
        int     i;
        longint tail;
        longint right_best;
        longint best;
        i          = n - 1;
        tail       = seq_samples[i];
        right_best = tail;
        best       = seq_left_best[i-1] + right_best;
        while (i > 0) begin
            i--;
            if (seq_left_best[i] + right_best > best)
                best = seq_left_best[i] + right_best;
            if (tail + seq_samples[i] > seq_samples[i])
                tail = tail + seq_samples[i];
            else
                tail = seq_samples[i];
            if (tail > right_best)
                right_best = tail;
        end
        return best[SUM_BITS-1:0];
    endfunction

    // Fold one accepted sample into the shadow state; queue a result on last
    function automatic void absorb_sample(logic signed [SW-1:0] value, logic is_last);
        longint s;
        t_status code;
        logic [SUM_BITS-1:0] total;
        s = longint'(value);
        if (seq_len < FRAME_CAP) begin
            if (seq_len == 0) begin
                run_tail = s;
                run_best = s;
            end else begin
                run_tail = (run_tail + s > s) ? run_tail + s : s;
                if (run_tail > run_best)
                    run_best = run_tail;
            end
            seq_samples[seq_len]   = s;
            seq_left_best[seq_len] = run_best;
            seq_len++;
        end else begin
            seq_dropped = 1'b1;
        end

        if (is_last) begin
            total = '0;
            if (seq_dropped) begin
                code = ST_OVERFLOW;
            end else if (seq_len < 2) begin
                code = ST_SHORT;
            end else begin
                code  = ST_OK;
                total = best_pair_total(seq_len);
            end
            due_sums.push_back(total);
            due_status.push_back(code);
            sequences_taken++;
            seq_len     = 0;
            run_tail    = 0;
            run_best    = 0;
            seq_dropped = 1'b0;
        end
    endfunction

    function automatic void log_mismatch(string what, longint want_sum, longint got_sum,
                                         int want_code, int got_code);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] MISMATCH %s: expected sum %0d status %0d, got sum %0d status %0d",
                     $realtime, what, want_sum, want_code, got_sum, got_code);
    endfunction

    // Compare one result transaction field by field with the oldest expectation
    function automatic void check_answer(logic [SUM_BITS-1:0] got_sum, logic [1:0] got_code);
        logic [SUM_BITS-1:0] want_sum;
        logic [1:0]          want_code;
        if (due_sums.size() == 0) begin
            log_mismatch("unexpected result", 0, $signed(got_sum), 0, got_code);
        end else begin
            want_sum  = due_sums.pop_front();
            want_code = due_status.pop_front();
            answers_checked++;
            if (got_sum !== want_sum)
                log_mismatch("best_sum", $signed(want_sum), $signed(got_sum),
                             want_code, got_code);
            if (got_code !== want_code)
                log_mismatch("status", $signed(want_sum), $signed(got_sum),
                             want_code, got_code);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both channels are sampled at the rising edge, before the
    // block's own updates land, so prediction comes ahead of checking even
    // when both transactions fall on one edge. Also runs the watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && o_in_ready) begin
                absorb_sample(i_sample, i_last);
                samples_taken++;
            end
            if (o_out_valid && i_out_ready)
                check_answer(o_best_sum, o_status);

            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("[%0t] watchdog: no transaction for %0d cycles",
                             $realtime, quiet_cycles);
                    $display("two_max_disjoint_subarray_sum test failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: one ready decision per edge. After each result it draws
    // a random stall (none with sink_no_idle); a long hold-off requested by a test is
    // counted down here, cycle by cycle.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1) begin
                if (o_out_valid && i_out_ready)
                    stall = sink_no_idle ? 0 : $urandom_range(0, 10);
                if (sink_hold > 0) begin
                    sink_hold--;
                    i_out_ready <= 1'b0;
                end else if (stall > 0) begin
                    stall--;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // Offer one sample after a random gap and hold it until accepted.
    // Valid stays high on return, so back-to-back calls with no gap stream without a bubble.
    task automatic send_sample(input logic signed [SW-1:0] value, input logic is_last);
        int gap;
        gap = src_no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        i_last     <= is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_sums.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [SW-1:0] draw_sample(t_fill fill);
        logic signed [SW-1:0] v;
        case (fill)
            FILL_FULL: begin
                v = SW'($urandom);
            end
            FILL_TINY: begin
                v = SW'(int'($urandom_range(0, 16)) - 8);
            end
            FILL_NEGATIVE: begin
                if ($urandom_range(0, 4) == 0)
                    v = SW'($urandom_range(0, 3000));
                else
                    v = SW'(-int'($urandom_range(1, 3000)));
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = SAMPLE_MIN;
                    1:       v = SAMPLE_MAX;
                    2:       v = 16'sd0;
                    3:       v = -16'sd1;
                    default: v = 16'sd1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Random-length sequence with one fill style
    task automatic send_sequence(input int len, input t_fill fill);
        for (int k = 0; k < len; k++)
            send_sample(draw_sample(fill), k == len - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, a single-sample sequence, all-negative and split cases
    task automatic test_extremes();
        send_sample(SAMPLE_MIN, 1'b1);                          // too short
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);                          // largest pair of singles
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);                          // smallest possible total
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd3, 1'b0);
        send_sample(-16'sd10, 1'b0);
        send_sample(16'sd4, 1'b0);
        send_sample(-16'sd10, 1'b0);
        send_sample(16'sd5, 1'b1);                              // best pair skips a gap
        send_sample(-16'sd1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-16'sd1, 1'b1);
        send_sample(-16'sd7, 1'b0);
        send_sample(-16'sd2, 1'b0);
        send_sample(-16'sd9, 1'b0);
        send_sample(-16'sd3, 1'b1);                             // all negative
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd4, 1'b1);                              // all positive, any split
        wait_drained();
    endtask

    // Store filled to the brim, then the dropped sample carries last
    task automatic test_capacity();
        src_no_idle = 1'b1;
        for (int k = 0; k < FRAME_CAP; k++)
            send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);                          // only the last mark overflows
        send_sample(16'sd42, 1'b0);
        send_sample(-16'sd42, 1'b1);                            // state cleared afterwards
        src_no_idle = 1'b0;
        wait_drained();
    endtask

    // Bulk random traffic: mostly short sequences, some single samples,
    // a few long ones; idling switched off for some sequences.
    task automatic test_random_sequences();
        int    sent;
        int    len;
        int    pick;
        t_fill fill;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                len = 1;
            else if (pick < 85)
                len = $urandom_range(2, 12);
            else if (pick < 96)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(41, 80);
            fill         = t_fill'($urandom_range(0, 3));
            src_no_idle  = ($urandom_range(0, 3) == 0);
            sink_no_idle = ($urandom_range(0, 3) == 0);
            send_sequence(len, fill);
            sent += len;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        src_no_idle  = 1'b0;
        sink_no_idle = 1'b0;
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while short sequences keep
    // coming, so the back end holds its result, the input queue fills and input transactions stall.
    task automatic test_output_backpressure();
        sink_hold   = HOLD_OFF;
        src_no_idle = 1'b1;
        for (int k = 0; k < 12; k++)
            send_sequence($urandom_range(2, 3), FILL_FULL);
        src_no_idle = 1'b0;
        wait_drained();
    endtask

    // Sender pauses for a full drain between bursts
    task automatic test_drain_pause();
        for (int k = 0; k < 4; k++) begin
            send_sequence($urandom_range(2, 6), FILL_TINY);
            send_sequence($urandom_range(1, 4), FILL_EXTREME);
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_sample   <= '0;
        i_last     <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_capacity();
        test_random_sequences();
        test_output_backpressure();
        test_drain_pause();

        // Anything arriving now is unexpected and shows up as a mismatch
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples in %0d sequences (short, full, overflow, random).",
                 samples_taken, sequences_taken);
        $display("Results checked: %0d, mismatches: %0d.", answers_checked, mismatch_count);
        if (mismatch_count == 0 && due_sums.size() == 0)
            $display("two_max_disjoint_subarray_sum test passed");
        else
            $display("two_max_disjoint_subarray_sum test failed");
        $finish;
    end

endmodule
